// ===== hdl/assert_macros.svh =====
// assertion helpers for the cpu step block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== hdl/ebcs_pkg.sv =====
package ebcs_pkg;
    localparam logic [1:0] OP_EXEC  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [7:0] res;
        logic       z;
        logic       n;
        logic       h;
        logic       c;
    } alu8_out_t;

    // shared 8-bit alu: codes 0..7 are add adc sub sbc and xor or cp
    function automatic alu8_out_t alu8(input logic [2:0] op, input logic [7:0] a,
                                       input logic [7:0] b, input logic cin_flag);
        alu8_out_t o;
        logic [8:0] s;
        logic [4:0] hs;
        logic       cin;
        begin
            cin = ((op == 3'd1) || (op == 3'd3)) ? cin_flag : 1'b0;
            o = '0;
            case (op)
                3'd0, 3'd1:
                begin
                    s = {1'b0, a} + {1'b0, b} + {8'd0, cin};
                    hs = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
                    o.res = s[7:0];
                    o.h = hs[4];
                    o.c = s[8];
                end
                3'd2, 3'd3, 3'd7:
                begin
                    s = {1'b0, a} - {1'b0, b} - {8'd0, cin};
                    hs = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
                    o.res = s[7:0];
                    o.n = 1'b1;
                    o.h = hs[4];
                    o.c = s[8];
                end
                3'd4:
                begin
                    o.res = a & b;
                    o.h = 1'b1;
                end
                3'd5: o.res = a ^ b;
                default: o.res = a | b;
            endcase
            o.z = (o.res == 8'd0);
            return o;
        end
    endfunction
endpackage

// ===== hdl/ebcs_ram.sv =====
module ebcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hdl/eight_bit_cpu_step.sv =====
// one instruction or memory access per input word
// input channel: valid/ready with operation, mem_address, mem_wdata
//   operation 0 runs the instruction at prog_counter, 1 writes a byte, 2 reads one
// output channel: valid/ready carrying all registers, flags, read_data, status
// one word at a time; a single-port byte memory with registered read is
// shared by fetch, immediates, operands and stack; a read passes through
// S_MWAIT and S_MRD and a write through S_MWR before S_DONE raises the
// valid result, and an undefined operation goes straight to S_DONE
// after reset every byte of the memory is cleared, one byte per cycle,
// while ready stays low; registers reset to zero
// a result waits in the output register while the receiver stalls, and
// no new word is taken until it is delivered
`include "assert_macros.svh"
module eight_bit_cpu_step
    import ebcs_pkg::*;
#(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [15:0] mem_address,
    input  logic [7:0]  mem_wdata,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  reg_a,
    output logic [7:0]  reg_b,
    output logic [7:0]  reg_c,
    output logic [7:0]  reg_d,
    output logic [7:0]  reg_e,
    output logic [7:0]  reg_h,
    output logic [7:0]  reg_l,
    output logic [7:0]  flag_byte,
    output logic [15:0] stack_ptr,
    output logic [15:0] prog_counter,
    output logic [7:0]  read_data,
    output logic        status
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FETCH, S_FWAIT, S_DECODE, S_MRD, S_MWAIT, S_MWR, S_DONE
    } state_t;

    // what to do once a memory byte arrives
    typedef enum logic [3:0] {
        K_OPC, K_CB, K_IMM8, K_IMM16LO, K_IMM16HI, K_OPND, K_POPLO, K_POPHI, K_RDOUT
    } kind_t;

    state_t state_reg;
    kind_t  kind_reg;
    logic [MEM_ADDR_BITS-1:0] clr_reg;
    logic [7:0]  a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, opc_reg, sub_reg;
    logic [7:0]  tmp_reg, rd_reg;
    logic [3:0]  f_reg;
    logic [15:0] sp_reg, pc_reg, addr_reg, imm_reg;
    logic [7:0]  wq0_reg, wq1_reg;
    logic [15:0] wa0_reg, wa1_reg;
    logic [1:0]  wn_reg;
    logic        stat_reg, ov_reg;

    logic        ram_we;
    logic [MEM_ADDR_BITS-1:0] ram_addr;
    logic [7:0]  ram_wdata, ram_rdata;

    ebcs_ram #(.WIDTH(8), .DEPTH(2 ** MEM_ADDR_BITS)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    always_comb
    begin
        ram_we = 1'b0;
        ram_addr = addr_reg[MEM_ADDR_BITS-1:0];
        ram_wdata = wq0_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                ram_addr = clr_reg;
                ram_wdata = 8'd0;
            end
            S_MWR:
            begin
                ram_we = 1'b1;
                ram_addr = wa0_reg[MEM_ADDR_BITS-1:0];
            end
            default: ;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign reg_a = a_reg;
    assign reg_b = b_reg;
    assign reg_c = c_reg;
    assign reg_d = d_reg;
    assign reg_e = e_reg;
    assign reg_h = h_reg;
    assign reg_l = l_reg;
    assign flag_byte = {f_reg, 4'd0};
    assign stack_ptr = sp_reg;
    assign prog_counter = pc_reg;
    assign read_data = rd_reg;
    assign status = stat_reg;

    function automatic logic [7:0] pick(input logic [2:0] code, input logic [7:0] a,
        input logic [7:0] b, input logic [7:0] c, input logic [7:0] d,
        input logic [7:0] e, input logic [7:0] h, input logic [7:0] l,
        input logic [7:0] m);
        case (code)
            3'd0: return b;
            3'd1: return c;
            3'd2: return d;
            3'd3: return e;
            3'd4: return h;
            3'd5: return l;
            3'd6: return m;
            default: return a;
        endcase
    endfunction

    // decode and execute, all in one block with blocking scratch
    logic [7:0]  na, nb, nc, nd, ne, nh, nl, v8, r8;
    logic [3:0]  nf;
    logic [15:0] nsp, hl, pv, sum16, off;
    logic [16:0] s17;
    logic [12:0] s13;
    logic [8:0]  s9;
    logic [4:0]  s5;
    state_t      nst;
    logic [7:0]  nwq0, nwq1;
    logic [15:0] nwa0, nwa1;
    logic [1:0]  nwn;
    logic        nstat;
    alu8_out_t   ao;
    logic [1:0]  p;
    logic [2:0]  hi3;
    logic [7:0]  op;

    always_comb
    begin
        na = a_reg; nb = b_reg; nc = c_reg; nd = d_reg; ne = e_reg; nh = h_reg;
        nl = l_reg; nf = f_reg; nsp = sp_reg; nst = S_DONE;
        nwq0 = wq0_reg; nwq1 = wq1_reg; nwa0 = wa0_reg;
        nwa1 = wa1_reg; nwn = 2'd0; nstat = stat_reg;
        op = opc_reg; p = op[5:4]; hi3 = op[5:3];
        hl = {h_reg, l_reg};
        v8 = 8'd0; r8 = 8'd0; pv = 16'd0; sum16 = 16'd0; off = 16'd0;
        s17 = '0; s13 = '0; s9 = '0; s5 = '0; ao = '0;
        case (p)
            2'd0: pv = {b_reg, c_reg};
            2'd1: pv = {d_reg, e_reg};
            2'd2: pv = hl;
            default: pv = sp_reg;
        endcase
        // operand byte: tmp_reg holds (hl) or immediate once read
        v8 = pick(op[2:0], a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, tmp_reg);
        if (op == 8'h00 || op == 8'h76 || op == 8'hf3 || op == 8'hfb || op == 8'h10)
            nst = S_DONE;
        else if (op[7:6] == 2'b01)
        begin
            if (hi3 == 3'd6)
            begin
                nwq0 = v8; nwa0 = hl; nwn = 2'd1;
            end
            else
            begin
                case (hi3)
                    3'd0: nb = v8;
                    3'd1: nc = v8;
                    3'd2: nd = v8;
                    3'd3: ne = v8;
                    3'd4: nh = v8;
                    3'd5: nl = v8;
                    default: na = v8;
                endcase
            end
        end
        else if (op[7:6] == 2'b10 || (op & 8'hc7) == 8'hc6)
        begin
            ao = alu8(hi3, a_reg, (op[7:6] == 2'b10) ? v8 : tmp_reg, f_reg[0]);
            nf = {ao.z, ao.n, ao.h, ao.c};
            if (hi3 != 3'd7) na = ao.res;
        end
        else if ((op & 8'hc7) == 8'h06 || (op & 8'hc6) == 8'h04)
        begin
            if ((op & 8'hc7) == 8'h06) r8 = tmp_reg;
            else
            begin
                v8 = pick(hi3, a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, tmp_reg);
                r8 = op[0] ? v8 - 8'd1 : v8 + 8'd1;
                nf = {r8 == 8'd0, op[0],
                      op[0] ? (v8[3:0] == 4'h0) : (v8[3:0] == 4'hf), f_reg[0]};
            end
            case (hi3)
                3'd0: nb = r8;
                3'd1: nc = r8;
                3'd2: nd = r8;
                3'd3: ne = r8;
                3'd4: nh = r8;
                3'd5: nl = r8;
                3'd6:
                begin
                    nwq0 = r8; nwa0 = hl; nwn = 2'd1;
                end
                default: na = r8;
            endcase
        end
        else if ((op & 8'hcf) == 8'h01 || (op & 8'hcf) == 8'h03 || (op & 8'hcf) == 8'h0b
                 || (op & 8'hcf) == 8'h09 || (op & 8'hcf) == 8'hc1)
        begin
            case (op & 8'hcf)
                8'h01: sum16 = imm_reg;
                8'h03: sum16 = pv + 16'd1;
                8'h0b: sum16 = pv - 16'd1;
                8'h09:
                begin
                    s17 = {1'b0, hl} + {1'b0, pv};
                    s13 = {1'b0, hl[11:0]} + {1'b0, pv[11:0]};
                    nf = {f_reg[3], 1'b0, s13[12], s17[16]};
                    p = 2'd2;
                    sum16 = s17[15:0];
                end
                default: sum16 = imm_reg;
            endcase
            if ((op & 8'hcf) == 8'hc1 && op[5:4] == 2'd3)
            begin
                na = imm_reg[15:8]; nf = imm_reg[7:4];
            end
            else
            begin
                case (p)
                    2'd0: {nb, nc} = sum16;
                    2'd1: {nd, ne} = sum16;
                    2'd2: {nh, nl} = sum16;
                    default: nsp = sum16;
                endcase
            end
        end
        else if ((op & 8'hcf) == 8'hc5)
        begin
            if (p == 2'd3) pv = {a_reg, f_reg, 4'd0};
            nsp = sp_reg - 16'd2;
            nwa0 = sp_reg - 16'd1; nwq0 = pv[15:8];
            nwa1 = sp_reg - 16'd2; nwq1 = pv[7:0]; nwn = 2'd2;
        end
        else
        begin
            case (op)
                8'h02, 8'h12, 8'h22, 8'h32, 8'hea, 8'he0, 8'he2:
                begin
                    nwq0 = a_reg; nwn = 2'd1;
                    case (op)
                        8'h02: nwa0 = {b_reg, c_reg};
                        8'h12: nwa0 = {d_reg, e_reg};
                        8'h22, 8'h32: nwa0 = hl;
                        8'hea: nwa0 = imm_reg;
                        8'he0: nwa0 = {8'hff, tmp_reg};
                        default: nwa0 = {8'hff, c_reg};
                    endcase
                    if (op == 8'h22) {nh, nl} = hl + 16'd1;
                    if (op == 8'h32) {nh, nl} = hl - 16'd1;
                end
                8'h0a, 8'h1a, 8'hfa, 8'hf0, 8'hf2: na = tmp_reg;
                8'h2a:
                begin
                    na = tmp_reg; {nh, nl} = hl + 16'd1;
                end
                8'h3a:
                begin
                    na = tmp_reg; {nh, nl} = hl - 16'd1;
                end
                8'hf9: nsp = hl;
                8'hf8, 8'he8:
                begin
                    off = {{8{tmp_reg[7]}}, tmp_reg};
                    s5 = {1'b0, sp_reg[3:0]} + {1'b0, tmp_reg[3:0]};
                    s9 = {1'b0, sp_reg[7:0]} + {1'b0, tmp_reg};
                    nf = {2'b00, s5[4], s9[8]};
                    if (op == 8'hf8) {nh, nl} = sp_reg + off;
                    else nsp = sp_reg + off;
                end
                8'h08:
                begin
                    nwa0 = imm_reg; nwq0 = sp_reg[7:0];
                    nwa1 = imm_reg + 16'd1; nwq1 = sp_reg[15:8]; nwn = 2'd2;
                end
                8'h2f:
                begin
                    na = ~a_reg; nf = f_reg | 4'b0110;
                end
                8'h3f: nf = {f_reg[3], 2'b00, ~f_reg[0]};
                8'h37: nf = {f_reg[3], 3'b001};
                8'h07, 8'h17:
                begin
                    na = {a_reg[6:0], (op == 8'h07) ? a_reg[7] : f_reg[0]};
                    nf = {3'b000, a_reg[7]};
                end
                8'hcb:
                begin
                    if (sub_reg[7:3] == 5'b00110)
                    begin
                        v8 = pick(sub_reg[2:0], a_reg, b_reg, c_reg, d_reg, e_reg,
                                  h_reg, l_reg, tmp_reg);
                        r8 = {v8[3:0], v8[7:4]};
                        nf = {r8 == 8'd0, 3'b000};
                        case (sub_reg[2:0])
                            3'd0: nb = r8;
                            3'd1: nc = r8;
                            3'd2: nd = r8;
                            3'd3: ne = r8;
                            3'd4: nh = r8;
                            3'd5: nl = r8;
                            3'd6:
                            begin
                                nwq0 = r8; nwa0 = hl; nwn = 2'd1;
                            end
                            default: na = r8;
                        endcase
                    end
                    else nstat = 1'b1;
                end
                default: nstat = 1'b1;
            endcase
        end
        if (nwn != 2'd0) nst = S_MWR;
    end

    // memory needs of an opcode: cb byte, immediate bytes, pop bytes and operand read
    logic need_cb, need_imm8, need_imm16, need_hl, need_pop, need_abs;
    always_comb
    begin
        need_cb = (opc_reg == 8'hcb);
        need_imm8 = ((opc_reg & 8'hc7) == 8'hc6) || ((opc_reg & 8'hc7) == 8'h06)
                    || opc_reg == 8'he0 || opc_reg == 8'hf0 || opc_reg == 8'hf8
                    || opc_reg == 8'he8 || opc_reg == 8'h10;
        need_imm16 = ((opc_reg & 8'hcf) == 8'h01) || opc_reg == 8'hea
                     || opc_reg == 8'hfa || opc_reg == 8'h08;
        need_pop = (opc_reg & 8'hcf) == 8'hc1;
        need_abs = opc_reg == 8'h0a || opc_reg == 8'h1a || opc_reg == 8'h2a
                   || opc_reg == 8'h3a || opc_reg == 8'hf2;
        need_hl = ((opc_reg[7:6] == 2'b01) && opc_reg[2:0] == 3'd6 && opc_reg != 8'h76)
                  || ((opc_reg[7:6] == 2'b10) && opc_reg[2:0] == 3'd6)
                  || (((opc_reg & 8'hc6) == 8'h04) && opc_reg[5:3] == 3'd6);
    end

    // address of the operand read, which follows any immediates
    function automatic logic [15:0] opnd_addr(input logic [7:0] o, input logic [15:0] hlv,
        input logic [15:0] bc, input logic [15:0] de, input logic [7:0] cv,
        input logic [15:0] imm, input logic [7:0] t);
        case (o)
            8'h0a: return bc;
            8'h1a: return de;
            8'hf2: return {8'hff, cv};
            8'hfa: return imm;
            8'hf0: return {8'hff, t};
            default: return hlv;
        endcase
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            kind_reg <= K_OPC;
            clr_reg <= '0;
            ov_reg <= 1'b0;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0;
            e_reg <= '0; h_reg <= '0; l_reg <= '0;
            f_reg <= '0; sp_reg <= '0; pc_reg <= '0;
            rd_reg <= '0; stat_reg <= 1'b0; wn_reg <= '0;
        end
        else
        begin
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        rd_reg <= '0;
                        stat_reg <= 1'b0;
                        case (operation)
                            OP_EXEC:
                            begin
                                addr_reg <= pc_reg;
                                pc_reg <= pc_reg + 16'd1;
                                kind_reg <= K_OPC;
                                state_reg <= S_MWAIT;
                            end
                            OP_WRITE:
                            begin
                                wa0_reg <= mem_address;
                                wq0_reg <= mem_wdata;
                                wn_reg <= 2'd1;
                                state_reg <= S_MWR;
                            end
                            OP_READ:
                            begin
                                addr_reg <= mem_address;
                                kind_reg <= K_RDOUT;
                                state_reg <= S_MWAIT;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_MWAIT: state_reg <= S_MRD;
                S_MRD:
                begin
                    state_reg <= S_DECODE;
                    case (kind_reg)
                        K_OPC: opc_reg <= ram_rdata;
                        K_CB: sub_reg <= ram_rdata;
                        K_IMM8: tmp_reg <= ram_rdata;
                        K_IMM16LO: imm_reg[7:0] <= ram_rdata;
                        K_IMM16HI: imm_reg[15:8] <= ram_rdata;
                        K_OPND: tmp_reg <= ram_rdata;
                        K_POPLO: imm_reg[7:0] <= ram_rdata;
                        K_POPHI: imm_reg[15:8] <= ram_rdata;
                        default:
                        begin
                            rd_reg <= ram_rdata;
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_DECODE:
                begin
                    // chain of reads; each branch but the last issues the next one, the last executes
                    state_reg <= S_MWAIT;
                    if (kind_reg == K_OPC && need_cb)
                    begin
                        addr_reg <= pc_reg; pc_reg <= pc_reg + 16'd1; kind_reg <= K_CB;
                    end
                    else if (kind_reg == K_OPC && need_imm8)
                    begin
                        addr_reg <= pc_reg; pc_reg <= pc_reg + 16'd1; kind_reg <= K_IMM8;
                    end
                    else if (kind_reg == K_OPC && need_imm16)
                    begin
                        addr_reg <= pc_reg; pc_reg <= pc_reg + 16'd1; kind_reg <= K_IMM16LO;
                    end
                    else if (kind_reg == K_IMM16LO)
                    begin
                        addr_reg <= pc_reg; pc_reg <= pc_reg + 16'd1; kind_reg <= K_IMM16HI;
                    end
                    else if (kind_reg == K_OPC && need_pop)
                    begin
                        addr_reg <= sp_reg; kind_reg <= K_POPLO;
                    end
                    else if (kind_reg == K_POPLO)
                    begin
                        addr_reg <= sp_reg + 16'd1; kind_reg <= K_POPHI;
                    end
                    else if ((kind_reg == K_OPC && (need_hl || need_abs))
                             || (kind_reg == K_IMM16HI && opc_reg == 8'hfa)
                             || (kind_reg == K_IMM8 && opc_reg == 8'hf0)
                             || (kind_reg == K_CB && sub_reg == 8'h36))
                    begin
                        addr_reg <= opnd_addr(opc_reg, {h_reg, l_reg}, {b_reg, c_reg},
                                              {d_reg, e_reg}, c_reg, imm_reg, tmp_reg);
                        kind_reg <= K_OPND;
                    end
                    else
                    begin
                        a_reg <= na; b_reg <= nb; c_reg <= nc; d_reg <= nd;
                        e_reg <= ne; h_reg <= nh; l_reg <= nl; f_reg <= nf;
                        // a pop never targets sp, so only the two-byte step applies
                        sp_reg <= (kind_reg == K_POPHI) ? sp_reg + 16'd2 : nsp;
                        stat_reg <= nstat;
                        wa0_reg <= nwa0; wq0_reg <= nwq0;
                        wa1_reg <= nwa1; wq1_reg <= nwq1; wn_reg <= nwn;
                        state_reg <= nst;
                    end
                end
                S_MWR:
                begin
                    if (wn_reg == 2'd2)
                    begin
                        wa0_reg <= wa1_reg; wq0_reg <= wq1_reg; wn_reg <= 2'd1;
                    end
                    else
                    begin
                        wn_reg <= 2'd0;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    ov_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !in_ready)
    `ASSERT_IMPLIES(a_f_when_out, clk, rst_n, ov_reg, state_reg == S_IDLE)
    `ASSERT_IMPLIES(a_wr_count, clk, rst_n, state_reg == S_MWR, wn_reg != 2'd0)
    `ASSERT_NEXT(a_done_valid, clk, rst_n, state_reg == S_DONE, ov_reg)
endmodule
